>>> src/assert_macros.svh
// assertion macros used by the top level rtl file
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error("invariant broken");
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error("implication broken");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

>>> src/psp_pkg.sv
// types, constants and helper functions of the printer status response parser
// no dependencies
package psp_pkg;

   localparam int unsigned MAX_BLOCK_BYTES_DEF = 32;
   localparam int unsigned CFG_W               = 6;
   localparam int unsigned ACK_FRAME_BYTES     = 8;
   localparam int unsigned ACK_PREFIX_BYTES    = 4;
   localparam int unsigned ACK_N1_POS          = 4;
   localparam int unsigned ACK_N2_POS          = 5;
   localparam int unsigned ACK_CNT_POS         = 6;
   localparam int unsigned STAT_CNT_POS        = 7;

   localparam logic [7:0] ESC_BYTE          = 8'h1B;
   localparam logic [7:0] GS_BYTE           = 8'h1D;
   localparam logic [7:0] ACK_CMD_BYTE      = 8'h03;
   localparam logic [7:0] ACK_SUB_BYTE      = 8'h01;
   localparam logic [7:0] STAT_CNT_HI_MASK  = 8'h60;
   localparam logic [7:0] STAT_CNT_LO_MASK  = 8'h0E;

   localparam logic [1:0] MODE_RX      = 2'd0;
   localparam logic [1:0] MODE_FLUSH   = 2'd1;
   localparam logic [1:0] MODE_DISCARD = 2'd2;

   localparam logic [1:0] KIND_ACK     = 2'd0;
   localparam logic [1:0] KIND_STATUS  = 2'd1;
   localparam logic [1:0] KIND_UNKNOWN = 2'd2;

   localparam logic CSR_STATUS_BLOCK_LENGTH = 1'b0;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] event_kind;
      logic [7:0] data_byte;
      logic [7:0] ack_first;
      logic [7:0] ack_second;
      logic [7:0] counter_value;
      logic       last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVAL,
      ST_PREFIX,
      ST_ACKDATA,
      ST_ACKPUSH,
      ST_COUNTER,
      ST_BLOCK,
      ST_UNKNOWN,
      ST_FINISH
   } state_type;

   function automatic logic [7:0] ack_prefix_byte(input logic [1:0] idx);
      logic [7:0] b;
      unique case (idx)
         2'd0: b = ESC_BYTE;
         2'd1: b = GS_BYTE;
         2'd2: b = ACK_CMD_BYTE;
         2'd3: b = ACK_SUB_BYTE;
      endcase
      return b;
   endfunction

   // bits 6,5 -> 4,3 and bits 3,2,1 -> 2,1,0
   function automatic logic [4:0] decode_counter(input logic [7:0] b);
      logic [7:0] t;
      t = ((b & STAT_CNT_HI_MASK) >> 2) | ((b & STAT_CNT_LO_MASK) >> 1);
      return t[4:0];
   endfunction

endpackage

>>> src/psp_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module psp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/printer_status_response_parser.sv
// top level of the printer status response parser: sequencer, csr and result buffering
// depends on psp_pkg, psp_ram and assert_macros.svh
`include "assert_macros.svh"

// Reply bytes are kept in a circular buffer in a single ram (one write port, one read port,
// registered read data) and a sequencer walks it one byte per cycle while the result side
// does not stall. Items are accepted only while idle. A scan pass looks at the front byte,
// checks the acknowledge prefix bytes after a 1B, then either decodes a complete acknowledge
// frame or gives out a complete status block byte by byte (reading its counter byte first
// when the block has eight bytes or more), and ends by releasing the final result.
// A front byte fitting neither, and each partial byte of a flush, goes out as an unknown byte.
// A result is handed out one transaction late so that its last flag is known;
// a stalled result side holds the sequencer. The buffer needs no clearing after reset.
module printer_status_response_parser #(
   parameter int unsigned MAX_BLOCK_BYTES = psp_pkg::MAX_BLOCK_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  psp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output psp_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import psp_pkg::*;

   localparam int unsigned PTR_W = $clog2(MAX_BLOCK_BYTES);
   localparam int unsigned CNT_W = $clog2(MAX_BLOCK_BYTES + 1);
   localparam int unsigned LEN_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int unsigned SUM_W = CNT_W + 1;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCK_BYTES);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BLOCK_BYTES);
   localparam logic [SUM_W-1:0] MAX_SUM = SUM_W'(MAX_BLOCK_BYTES);

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] idx_ff, idx_in;
   logic             force_ff, force_in;
   logic [7:0]       b0_ff, b0_in;
   logic [7:0]       n1_ff, n1_in;
   logic [7:0]       n2_ff, n2_in;
   logic [7:0]       n3_ff, n3_in;
   logic [4:0]       cnt_ff, cnt_in;
   rsp_type          held_ff, held_in;
   logic             held_valid_ff, held_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CFG_W-1:0] cfg_len_ff, cfg_len_in;

   logic [PTR_W-1:0] rd_idx;
   logic [PTR_W-1:0] rd_addr;
   logic [PTR_W-1:0] wr_addr;
   logic [SUM_W-1:0] rd_sum, wr_sum, drop_sum;
   logic [SUM_W-1:0] rd_wrap, wr_wrap, drop_wrap;
   logic             ram_we;
   logic [7:0]       ram_rdata;
   logic [CNT_W-1:0] drop_n;
   logic             do_drop;
   logic [LEN_W-1:0] cfg_ext;
   logic [CNT_W-1:0] len_eff;
   logic [CNT_W-1:0] idx_next;
   logic             out_free;
   logic             can_push;
   logic             push;
   rsp_type          push_data;
   logic             pop_last;
   logic             csr_write;

   // csr
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == CSR_STATUS_BLOCK_LENGTH);
   assign cfg_len_in = csr_write ? pwdata[CFG_W-1:0] : cfg_len_ff;
   assign prdata = (paddr[2] == CSR_STATUS_BLOCK_LENGTH) ? 32'(cfg_len_ff) : '0;

   // block length clamped to the buffer size
   assign cfg_ext = LEN_W'(cfg_len_ff);
   assign len_eff = (cfg_ext > MAX_LEN) ? MAX_CNT : cfg_ext[CNT_W-1:0];

   assign idx_next = CNT_W'(idx_ff) + CNT_W'(1);

   // circular buffer addressing
   assign rd_sum    = SUM_W'(head_ff) + SUM_W'(rd_idx);
   assign rd_wrap   = (rd_sum >= MAX_SUM) ? (rd_sum - MAX_SUM) : rd_sum;
   assign rd_addr   = rd_wrap[PTR_W-1:0];
   assign wr_sum    = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign wr_wrap   = (wr_sum >= MAX_SUM) ? (wr_sum - MAX_SUM) : wr_sum;
   assign wr_addr   = wr_wrap[PTR_W-1:0];
   assign drop_sum  = SUM_W'(head_ff) + SUM_W'(drop_n);
   assign drop_wrap = (drop_sum >= MAX_SUM) ? (drop_sum - MAX_SUM) : drop_sum;

   // appends happen only while idle and read data is used only during a scan, so no
   // entry is written and has its read data used in the same cycle
   psp_ram #(
      .WIDTH (8),
      .DEPTH (MAX_BLOCK_BYTES)
   ) u_buf (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr),
      .wr_data (req_data.rx_byte),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign can_push = !held_valid_ff || out_free;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      force_in  = force_ff;
      b0_in     = b0_ff;
      n1_in     = n1_ff;
      n2_in     = n2_ff;
      n3_in     = n3_ff;
      cnt_in    = cnt_ff;
      rd_idx    = idx_ff;
      ram_we    = 1'b0;
      push      = 1'b0;
      push_data = '0;
      pop_last  = 1'b0;
      do_drop   = 1'b0;
      drop_n    = '0;
      count_in  = count_ff;
      head_in   = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.mode)
                  MODE_RX: begin
                     if (count_ff < MAX_CNT) begin
                        ram_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                     force_in = 1'b0;
                     state_in = ST_SCAN;
                  end
                  MODE_FLUSH: begin
                     force_in = 1'b1;
                     state_in = ST_SCAN;
                  end
                  MODE_DISCARD: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (count_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               rd_idx   = '0;
               idx_in   = '0;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            b0_in = ram_rdata;
            if (ram_rdata == ESC_BYTE) begin
               if (count_ff > CNT_W'(1)) begin
                  rd_idx   = PTR_W'(1);
                  idx_in   = PTR_W'(1);
                  state_in = ST_PREFIX;
               end else begin
                  state_in = force_ff ? ST_UNKNOWN : ST_FINISH;
               end
            end else if (len_eff == '0) begin
               state_in = ST_UNKNOWN;
            end else if (count_ff < len_eff) begin
               state_in = force_ff ? ST_UNKNOWN : ST_FINISH;
            end else if (len_eff > CNT_W'(STAT_CNT_POS)) begin
               rd_idx   = PTR_W'(STAT_CNT_POS);
               idx_in   = PTR_W'(STAT_CNT_POS);
               state_in = ST_COUNTER;
            end else begin
               cnt_in   = '0;
               rd_idx   = '0;
               idx_in   = '0;
               state_in = ST_BLOCK;
            end
         end
         ST_PREFIX: begin
            if (ram_rdata != ack_prefix_byte(idx_ff[1:0])) begin
               state_in = ST_UNKNOWN;
            end else if (idx_next < count_ff && idx_next < CNT_W'(ACK_PREFIX_BYTES)) begin
               rd_idx = idx_next[PTR_W-1:0];
               idx_in = idx_next[PTR_W-1:0];
            end else if (count_ff < CNT_W'(ACK_FRAME_BYTES)) begin
               state_in = force_ff ? ST_UNKNOWN : ST_FINISH;
            end else begin
               rd_idx   = PTR_W'(ACK_N1_POS);
               idx_in   = PTR_W'(ACK_N1_POS);
               state_in = ST_ACKDATA;
            end
         end
         ST_ACKDATA: begin
            if (idx_ff == PTR_W'(ACK_N1_POS)) begin
               n1_in = ram_rdata;
            end else if (idx_ff == PTR_W'(ACK_N2_POS)) begin
               n2_in = ram_rdata;
            end else begin
               n3_in = ram_rdata;
            end
            if (idx_ff == PTR_W'(ACK_CNT_POS)) begin
               state_in = ST_ACKPUSH;
            end else begin
               rd_idx = idx_next[PTR_W-1:0];
               idx_in = idx_next[PTR_W-1:0];
            end
         end
         ST_ACKPUSH: begin
            if (can_push) begin
               push                    = 1'b1;
               push_data.event_kind    = KIND_ACK;
               push_data.ack_first     = n1_ff;
               push_data.ack_second    = n2_ff;
               push_data.counter_value = n3_ff;
               do_drop                 = 1'b1;
               drop_n                  = CNT_W'(ACK_FRAME_BYTES);
               state_in                = ST_SCAN;
            end
         end
         ST_COUNTER: begin
            cnt_in   = decode_counter(ram_rdata);
            rd_idx   = '0;
            idx_in   = '0;
            state_in = ST_BLOCK;
         end
         ST_BLOCK: begin
            if (can_push) begin
               push                 = 1'b1;
               push_data.event_kind = KIND_STATUS;
               push_data.data_byte  = ram_rdata;
               if (idx_next == len_eff) begin
                  push_data.counter_value = 8'(cnt_ff);
                  do_drop                 = 1'b1;
                  drop_n                  = len_eff;
                  state_in                = ST_SCAN;
               end else begin
                  rd_idx = idx_next[PTR_W-1:0];
                  idx_in = idx_next[PTR_W-1:0];
               end
            end
         end
         ST_UNKNOWN: begin
            if (can_push) begin
               push                 = 1'b1;
               push_data.event_kind = KIND_UNKNOWN;
               push_data.data_byte  = b0_ff;
               do_drop              = 1'b1;
               drop_n               = CNT_W'(1);
               state_in             = ST_SCAN;
            end
         end
         ST_FINISH: begin
            if (!held_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               pop_last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (do_drop) begin
         head_in  = drop_wrap[PTR_W-1:0];
         count_in = count_ff - drop_n;
      end
   end

   // result buffering: the newest result waits in held until its successor or the end
   always_comb begin
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (push) begin
         if (held_valid_ff) begin
            rsp_in       = held_ff;
            rsp_in.last  = 1'b0;
            rsp_valid_in = 1'b1;
         end
         held_in       = push_data;
         held_valid_in = 1'b1;
      end else if (pop_last) begin
         rsp_in        = held_ff;
         rsp_in.last   = 1'b1;
         rsp_valid_in  = 1'b1;
         held_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         force_ff      <= 1'b0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cfg_len_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         force_ff      <= force_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         cfg_len_ff    <= cfg_len_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      b0_ff   <= b0_in;
      n1_ff   <= n1_in;
      n2_ff   <= n2_in;
      n3_ff   <= n3_in;
      cnt_ff  <= cnt_in;
      held_ff <= held_in;
      rsp_ff  <= rsp_in;
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= MAX_CNT)
   `ASSERT_ALWAYS(a_head_bound, clock, reset, CNT_W'(head_ff) < MAX_CNT)
   `ASSERT_IMPLY(a_idle_nothing_held, clock, reset, state_ff == ST_IDLE, !held_valid_ff)
   `ASSERT_IMPLY(a_block_in_buffer, clock, reset, state_ff == ST_BLOCK, idx_next <= len_eff && len_eff <= count_ff)

endmodule
